### sv/kcq_pkg.sv
package kcq_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_CENT = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  localparam logic REG_NUM_CLUSTERS = 1'b0;
  localparam logic REG_MAX_ITER     = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int COLOR_W    = 8;
  localparam int SLOT_W     = 12;
  localparam int LABEL_W    = 4;
  localparam int NUMK_W     = 5;
  localparam int MAXIT_W    = 8;
  localparam int CEN_CH_W   = 16;
  localparam int SQ_W       = 34;
  localparam int DIST_W     = 36;

  localparam logic [NUMK_W-1:0]  NUM_CLUSTERS_RST = 5'd8;
  localparam logic [MAXIT_W-1:0] MAX_ITER_RST     = 8'd10;

  // Round an 8.8 centroid channel half up to an integer, saturating at 255.
  function automatic logic [COLOR_W-1:0] round_ch(input logic [CEN_CH_W-1:0] c);
    logic [CEN_CH_W:0] s;
    s = {1'b0, c} + 17'd128;
    return s[CEN_CH_W] ? 8'hFF : s[CEN_CH_W-1:8];
  endfunction

endpackage

### sv/kcq_in_if.sv
interface kcq_in_if;
  import kcq_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [SLOT_W-1:0]  slot;
  logic               last_pixel;
  modport source (output valid, req_type, red, green, blue, slot, last_pixel, input ready);
  modport sink (input valid, req_type, red, green, blue, slot, last_pixel, output ready);
endinterface

### sv/kcq_out_if.sv
interface kcq_out_if;
  import kcq_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_red;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_blue;
  logic [LABEL_W-1:0] cluster;
  modport source (output valid, out_red, out_green, out_blue, cluster, input ready);
  modport sink (input valid, out_red, out_green, out_blue, cluster, output ready);
endinterface

### sv/kcq_div.sv
module kcq_div #(
  parameter int NW = 29,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CTW = $clog2(NW + 1);

  logic          busy_r, done_r;
  logic [CTW-1:0] ctr_r;
  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] q_r;
  logic [DW:0]   shifted, diff;
  logic          ge;

  always_comb begin
    shifted = {rem_r, q_r[NW-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ctr_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ctr_r  <= CTW'(NW);
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        q_r   <= {q_r[NW-2:0], ge};
        ctr_r <= ctr_r - CTW'(1);
        if (ctr_r == CTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
endmodule

### sv/kmeans_color_quantizer.sv
// Pixel load and centroid write: one beat per cycle while the block is idle, no result.
// Readback: label read, then centroid read and round into the output register when it is free.
// Clustering after the last pixel: each pass scans the pixel memory, then, if any label changed,
// updates each non-empty cluster's centroid channel by channel in the shared divider.
// Reset (synchronous, active low) clears control state and sets K = 8 and 10 passes;
// pixel and centroid memories hold garbage until written, labels read as zero.
module kmeans_color_quantizer #(
  parameter int MAX_PIXELS   = 4096,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kcq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kcq_pkg::CFG_DATA_W-1:0]   cfg_data,
  kcq_in_if.sink                           in_ch,
  kcq_out_if.source                        out_ch
);
  import kcq_pkg::*;

  localparam int PAW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNTW = $clog2(MAX_PIXELS + 1);
  localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int KCW  = (KW > NUMK_W) ? KW : NUMK_W;
  localparam int SUMW = COLOR_W + CNTW;
  localparam int NW   = SUMW + 8;
  localparam int CMPW = (CNTW > SLOT_W) ? CNTW : SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_PASS, S_PRD, S_PLAT, S_SCAN, S_PWR, S_PEND,
    S_DSEL, S_DGO, S_DWAIT, S_RLAB, S_RCEN
  } state_t;

  state_t state_r, state_nxt;
  logic [NUMK_W-1:0]  numk_r;
  logic [MAXIT_W-1:0] maxit_r;
  logic [CNTW-1:0]    cnt_r, cnt_nxt, i_r, i_nxt, base;
  logic [CNTW-1:0]    labn_r, labn_nxt;
  logic               done_img_r, done_img_nxt;
  logic [MAXIT_W-1:0] it_r, it_nxt;
  logic               first_r, first_nxt, labz_r, labz_nxt, chg_r, chg_nxt;
  logic [23:0]        px_r, px_nxt;
  logic [CW-1:0]      old_r, old_nxt;
  logic [KW-1:0]      jiss_r, jiss_nxt, dj_r, dj_nxt;
  logic               v1_r, v1_nxt, v2_r;
  logic [CW-1:0]      j1_r, j2_r;
  logic [SQ_W-1:0]    sq_r [3];
  logic [SQ_W-1:0]    sq_nxt [3];
  logic [DIST_W-1:0]  bestd_r, bestd_nxt, dsum;
  logic [CW-1:0]      bestj_r, bestj_nxt, rlab_r, rlab_nxt, lab_sel;
  logic [1:0]         dc_r, dc_nxt;
  logic [CEN_CH_W-1:0] q0_r, q0_nxt, q1_r, q1_nxt;
  logic               rzero_r, rzero_nxt, rlz_r, rlz_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [COLOR_W-1:0] ored_r, ored_nxt, ogrn_r, ogrn_nxt, oblu_r, oblu_nxt;
  logic [LABEL_W-1:0] oclu_r, oclu_nxt;
  logic [KW-1:0]      k_used;
  logic [KCW-1:0]     numk_ext;
  logic               accept, sum_clr, acc;
  logic [CMPW-1:0]    slot_ext;

  // Memories.
  logic [23:0]             pix_mem [MAX_PIXELS];
  logic [CW-1:0]           lab_mem [MAX_PIXELS];
  logic [3*CEN_CH_W-1:0]   cen_mem [MAX_CLUSTERS];
  logic [23:0]             pix_rd_r;
  logic [CW-1:0]           lab_rd_r;
  logic [3*CEN_CH_W-1:0]   cen_rd_r;
  logic                    pix_we, lab_we, cen_we;
  logic [PAW-1:0]          pix_wa, lab_ra;
  logic [CW-1:0]           cen_wa, cen_ra;
  logic [3*CEN_CH_W-1:0]   cen_wd;

  // Per-cluster accumulators.
  logic [SUMW-1:0] sums_r [MAX_CLUSTERS][3];
  logic [CNTW-1:0] cnts_r [MAX_CLUSTERS];

  logic            div_start, div_busy, div_done;
  logic [NW-1:0]   div_quo;

  kcq_div #(.NW(NW), .DW(CNTW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({sums_r[dj_r[CW-1:0]][dc_r], 8'b0}),
    .den   (cnts_r[dj_r[CW-1:0]]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    numk_ext = KCW'(numk_r);
    if (numk_ext == '0) k_used = KW'(1);
    else if (numk_ext > KCW'(MAX_CLUSTERS)) k_used = KW'(MAX_CLUSTERS);
    else k_used = KW'(numk_ext);
  end

  // Distance pipeline: squares from the centroid read, then sum.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [16:0] d;
      logic signed [33:0] p;
      d = $signed({1'b0, px_r[23-8*c -: 8], 8'b0})
        - $signed({1'b0, cen_rd_r[47-16*c -: 16]});
      p = d * d;
      sq_nxt[c] = p;
    end
    dsum = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign slot_ext = CMPW'(in_ch.slot);
  // Labels read as zero past the last clustered image and until a first pass has written them.
  assign lab_sel  = (labz_r || rlz_r) ? '0 : lab_rd_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; done_img_nxt = done_img_r; it_nxt = it_r;
    first_nxt = first_r; labz_nxt = labz_r; chg_nxt = chg_r; i_nxt = i_r;
    labn_nxt = labn_r;
    px_nxt = px_r; old_nxt = old_r; jiss_nxt = jiss_r; dj_nxt = dj_r; dc_nxt = dc_r;
    bestd_nxt = bestd_r; bestj_nxt = bestj_r; q0_nxt = q0_r; q1_nxt = q1_r;
    rlab_nxt = rlab_r; rzero_nxt = rzero_r; rlz_nxt = rlz_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ored_nxt = ored_r; ogrn_nxt = ogrn_r; oblu_nxt = oblu_r; oclu_nxt = oclu_r;
    v1_nxt = 1'b0; sum_clr = 1'b0; acc = 1'b0; div_start = 1'b0;
    pix_we = 1'b0; lab_we = 1'b0; cen_we = 1'b0;
    base = done_img_r ? '0 : cnt_r;
    pix_wa = base[PAW-1:0];
    lab_ra = (state_r == S_IDLE) ? slot_ext[PAW-1:0] : i_r[PAW-1:0];
    cen_wa = in_ch.slot[CW-1:0];
    cen_wd = {in_ch.red, 8'b0, in_ch.green, 8'b0, in_ch.blue, 8'b0};
    case (state_r)
      S_SCAN:  cen_ra = jiss_r[CW-1:0];
      S_RLAB:  cen_ra = lab_sel;
      default: cen_ra = rlab_r;
    endcase

    if (v2_r && (j2_r == '0 || dsum < bestd_r)) begin
      bestd_nxt = dsum;
      bestj_nxt = j2_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(in_ch.req_type))
            REQ_LOAD: begin
              done_img_nxt = 1'b0;
              cnt_nxt = base;
              if (base < CNTW'(MAX_PIXELS)) begin
                pix_we = 1'b1;
                cnt_nxt = base + CNTW'(1);
              end
              if (in_ch.last_pixel) begin
                done_img_nxt = 1'b1;
                state_nxt = S_INIT;
              end
            end
            REQ_CENT: cen_we = ({1'b0, in_ch.slot} < 13'(MAX_CLUSTERS));
            REQ_READ: begin
              rzero_nxt = slot_ext >= CMPW'(cnt_r);
              rlz_nxt = slot_ext >= CMPW'(labn_r);
              state_nxt = S_RLAB;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        it_nxt = '0;
        first_nxt = 1'b1;
        labz_nxt = 1'b1;
        state_nxt = S_PASS;
      end
      S_PASS: begin
        if (it_r == maxit_r) begin
          state_nxt = S_IDLE;
        end else begin
          sum_clr = 1'b1;
          chg_nxt = 1'b0;
          i_nxt = '0;
          state_nxt = (cnt_r == '0) ? S_PEND : S_PRD;
        end
      end
      S_PRD: state_nxt = S_PLAT;
      S_PLAT: begin
        px_nxt = pix_rd_r;
        // Labels count as zero until the first pass has written them.
        old_nxt = first_r ? '0 : lab_rd_r;
        jiss_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (jiss_r < k_used) begin
          v1_nxt = 1'b1;
          jiss_nxt = jiss_r + KW'(1);
        end
        if (v2_r && KW'(j2_r) == k_used - KW'(1)) state_nxt = S_PWR;
      end
      S_PWR: begin
        lab_we = 1'b1;
        acc = 1'b1;
        chg_nxt = chg_r || (bestj_r != old_r);
        i_nxt = i_r + CNTW'(1);
        state_nxt = (i_r + CNTW'(1) == cnt_r) ? S_PEND : S_PRD;
      end
      S_PEND: begin
        first_nxt = 1'b0;
        labz_nxt = 1'b0;
        labn_nxt = cnt_r;
        dj_nxt = '0;
        state_nxt = chg_r ? S_DSEL : S_IDLE;
      end
      S_DSEL: begin
        if (dj_r == k_used) begin
          it_nxt = it_r + MAXIT_W'(1);
          state_nxt = S_PASS;
        end else if (cnts_r[dj_r[CW-1:0]] == '0) begin
          // An empty cluster keeps its centroid.
          dj_nxt = dj_r + KW'(1);
        end else begin
          dc_nxt = '0;
          state_nxt = S_DGO;
        end
      end
      S_DGO: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        cen_wa = dj_r[CW-1:0];
        cen_wd = {q0_r, q1_r, div_quo[CEN_CH_W-1:0]};
        if (div_done) begin
          if (dc_r == 2'd2) begin
            cen_we = 1'b1;
            dj_nxt = dj_r + KW'(1);
            state_nxt = S_DSEL;
          end else begin
            if (dc_r == 2'd0) q0_nxt = div_quo[CEN_CH_W-1:0];
            else q1_nxt = div_quo[CEN_CH_W-1:0];
            dc_nxt = dc_r + 2'd1;
            state_nxt = S_DGO;
          end
        end
      end
      S_RLAB: begin
        rlab_nxt = lab_sel;
        state_nxt = S_RCEN;
      end
      S_RCEN: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          ored_nxt = rzero_r ? '0 : round_ch(cen_rd_r[47:32]);
          ogrn_nxt = rzero_r ? '0 : round_ch(cen_rd_r[31:16]);
          oblu_nxt = rzero_r ? '0 : round_ch(cen_rd_r[15:0]);
          oclu_nxt = rzero_r ? '0 : LABEL_W'(rlab_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_wa] <= {in_ch.red, in_ch.green, in_ch.blue};
    pix_rd_r <= pix_mem[i_r[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[i_r[PAW-1:0]] <= bestj_r;
    lab_rd_r <= lab_mem[lab_ra];
  end

  always_ff @(posedge clk) begin
    if (cen_we) cen_mem[cen_wa] <= cen_wd;
    cen_rd_r <= cen_mem[cen_ra];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      if (sum_clr) begin
        cnts_r[k] <= '0;
        for (int c = 0; c < 3; c++) sums_r[k][c] <= '0;
      end else if (acc && bestj_r == CW'(k)) begin
        cnts_r[k] <= cnts_r[k] + CNTW'(1);
        for (int c = 0; c < 3; c++)
          sums_r[k][c] <= sums_r[k][c] + SUMW'(px_r[23-8*c -: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      numk_r     <= NUM_CLUSTERS_RST;
      maxit_r    <= MAX_ITER_RST;
      cnt_r      <= '0;
      labn_r     <= '0;
      done_img_r <= 1'b0;
      it_r       <= '0;
      first_r    <= 1'b0;
      labz_r     <= 1'b1;
      chg_r      <= 1'b0;
      i_r        <= '0;
      jiss_r     <= '0;
      dj_r       <= '0;
      dc_r       <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      rzero_r    <= 1'b0;
      rlz_r      <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we && cfg_index == REG_NUM_CLUSTERS) numk_r <= cfg_data[NUMK_W-1:0];
      if (cfg_we && cfg_index == REG_MAX_ITER) maxit_r <= cfg_data[MAXIT_W-1:0];
      cnt_r      <= cnt_nxt;
      labn_r     <= labn_nxt;
      done_img_r <= done_img_nxt;
      it_r       <= it_nxt;
      first_r    <= first_nxt;
      labz_r     <= labz_nxt;
      chg_r      <= chg_nxt;
      i_r        <= i_nxt;
      jiss_r     <= jiss_nxt;
      dj_r       <= dj_nxt;
      dc_r       <= dc_nxt;
      v1_r       <= v1_nxt;
      v2_r       <= v1_r;
      rzero_r    <= rzero_nxt;
      rlz_r      <= rlz_nxt;
      ovalid_r   <= ovalid_nxt;
      j1_r       <= jiss_r[CW-1:0];
      j2_r       <= j1_r;
      sq_r       <= sq_nxt;
      bestd_r    <= bestd_nxt;
      bestj_r    <= bestj_nxt;
      px_r       <= px_nxt;
      old_r      <= old_nxt;
      q0_r       <= q0_nxt;
      q1_r       <= q1_nxt;
      rlab_r     <= rlab_nxt;
      ored_r     <= ored_nxt;
      ogrn_r     <= ogrn_nxt;
      oblu_r     <= oblu_nxt;
      oclu_r     <= oclu_nxt;
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = ovalid_r;
  assign out_ch.out_red   = ored_r;
  assign out_ch.out_green = ogrn_r;
  assign out_ch.out_blue  = oblu_r;
  assign out_ch.cluster   = oclu_r;

  // The distance pipeline must be drained before a label is committed.
  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PWR |-> !v1_r && !v2_r)
    else $error("label committed with distance pipeline busy");

  a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PWR |-> KW'(bestj_r) < k_used)
    else $error("label outside active clusters");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_PIXELS))
    else $error("pixel count beyond store depth");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

### test/tb_kmeans_color_quantizer.sv
`timescale 1ns / 100ps

module tb_kmeans_color_quantizer;
  import kcq_pkg::*;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [LABEL_W-1:0] label;
  } quant_px_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kcq_in_if  in_ch();
  kcq_out_if out_ch();

  kmeans_color_quantizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow of the block state, updated as each beat is accepted.
  logic [23:0]         pix_mem [4096];
  logic [LABEL_W-1:0]  lab_mem [4096];
  logic [CEN_CH_W-1:0] cen_mem [16][3];
  int                  pix_cnt;
  bit                  img_done;
  int                  k_reg;
  int                  iter_reg;

  quant_px_t pending_px[$];
  int        err_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_arm;
  bit        holding;

  always #5 clk = ~clk;

  always begin
    wait (hold_arm);
    hold_arm = 1'b0;
    holding  = 1'b1;
    repeat (400) @(posedge clk);
    holding  = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    quant_px_t exp_px;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_px.size() == 0) begin
        $error("unexpected result beat: red %0d green %0d blue %0d cluster %0d",
               out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.cluster);
        err_cnt++;
      end else begin
        exp_px = pending_px.pop_front();
        if (out_ch.out_red !== exp_px.red) begin
          $error("out_red: expected %0d actual %0d", exp_px.red, out_ch.out_red);
          err_cnt++;
        end
        if (out_ch.out_green !== exp_px.green) begin
          $error("out_green: expected %0d actual %0d", exp_px.green, out_ch.out_green);
          err_cnt++;
        end
        if (out_ch.out_blue !== exp_px.blue) begin
          $error("out_blue: expected %0d actual %0d", exp_px.blue, out_ch.out_blue);
          err_cnt++;
        end
        if (out_ch.cluster !== exp_px.label) begin
          $error("cluster: expected %0d actual %0d", exp_px.label, out_ch.cluster);
          err_cnt++;
        end
      end
    end
  end

  task automatic cluster_pixels();
    int k, it, i, j, c, best;
    longint unsigned d, best_d;
    longint diff;
    bit changed;
    longint unsigned ch_sum [16][3];
    int members [16];
    k = (k_reg < 1) ? 1 : ((k_reg > 16) ? 16 : k_reg);
    for (i = 0; i < 4096; i++) lab_mem[i] = '0;
    for (it = 0; it < iter_reg; it++) begin
      changed = 1'b0;
      for (i = 0; i < pix_cnt; i++) begin
        best   = 0;
        best_d = 0;
        for (j = 0; j < k; j++) begin
          d = 0;
          for (c = 0; c < 3; c++) begin
            diff = longint'({pix_mem[i][23-8*c -: 8], 8'h00}) - longint'(cen_mem[j][c]);
            d += longint'(diff * diff);
          end
          if (j == 0 || d < best_d) begin
            best_d = d;
            best   = j;
          end
        end
        if (lab_mem[i] != best[3:0]) begin
          lab_mem[i] = best[3:0];
          changed    = 1'b1;
        end
      end
      if (!changed) break;
      for (j = 0; j < 16; j++) begin
        members[j] = 0;
        for (c = 0; c < 3; c++) ch_sum[j][c] = 0;
      end
      for (i = 0; i < pix_cnt; i++) begin
        for (c = 0; c < 3; c++) ch_sum[lab_mem[i]][c] += pix_mem[i][23-8*c -: 8];
        members[lab_mem[i]]++;
      end
      for (j = 0; j < k; j++) begin
        if (members[j] > 0) begin
          for (c = 0; c < 3; c++) cen_mem[j][c] = 16'((ch_sum[j][c] << 8) / members[j]);
        end
      end
    end
  endtask

  function automatic logic [COLOR_W-1:0] round_channel(logic [CEN_CH_W-1:0] c);
    int v;
    v = (int'(c) + 128) >> 8;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic predict_beat(req_t kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [11:0] slot, logic last);
    quant_px_t px;
    logic [LABEL_W-1:0] lab;
    case (kind)
      REQ_LOAD: begin
        if (img_done) begin
          pix_cnt  = 0;
          img_done = 1'b0;
        end
        if (pix_cnt < 4096) begin
          pix_mem[pix_cnt] = {r, g, b};
          pix_cnt++;
        end
        if (last) begin
          cluster_pixels();
          img_done = 1'b1;
        end
      end
      REQ_CENT: begin
        if (slot < 16) begin
          cen_mem[slot][0] = {r, 8'h00};
          cen_mem[slot][1] = {g, 8'h00};
          cen_mem[slot][2] = {b, 8'h00};
        end
      end
      REQ_READ: begin
        if (slot >= pix_cnt) begin
          px = '{default: '0};
        end else begin
          lab      = lab_mem[slot];
          px.red   = round_channel(cen_mem[lab][0]);
          px.green = round_channel(cen_mem[lab][1]);
          px.blue  = round_channel(cen_mem[lab][2]);
          px.label = lab;
        end
        pending_px.insert(pending_px.size(), px);
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(req_t kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [11:0] slot, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.red        <= r;
    in_ch.green      <= g;
    in_ch.blue       <= b;
    in_ch.slot       <= slot;
    in_ch.last_pixel <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_beat(kind, r, g, b, slot, last);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[7:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_NUM_CLUSTERS) k_reg = value & 31;
    else iter_reg = value & 255;
  endtask

  // The readback is held off until clustering ends, so once it returns the block is idle.
  task automatic drain();
    send_beat(REQ_READ, 8'd0, 8'd0, 8'd0, (pix_cnt == 4096) ? 12'd0 : 12'd4095, 1'b0);
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_clusters(int k, int iters);
    drain();
    write_reg(REG_NUM_CLUSTERS, k);
    write_reg(REG_MAX_ITER, iters);
  endtask

  task automatic read_random(bit in_range);
    if (in_range && img_done && pix_cnt > 0)
      send_beat(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                12'($urandom_range(pix_cnt - 1)), 1'b0);
    else
      send_beat(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                12'($urandom_range(4095, (pix_cnt < 4096) ? pix_cnt : 4095)), 1'b0);
  endtask

  // One image with noise beats mixed in, then readbacks of the clustered result.
  task automatic random_image(int n);
    int i;
    bit palette;
    logic [23:0] base [4];
    logic [23:0] px;
    palette = 1'($urandom_range(1));
    for (i = 0; i < 4; i++) base[i] = 24'($urandom);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: send_beat(REQ_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                     12'($urandom), 1'($urandom));
        1: send_beat(REQ_CENT, 8'($urandom), 8'($urandom), 8'($urandom),
                     12'($urandom_range(1) ? $urandom_range(15) : $urandom), 1'b0);
        2: read_random(1'b0);
        default: ;
      endcase
      px = palette ? (base[$urandom_range(3)] ^ (24'($urandom) & 24'h070707))
                   : 24'($urandom);
      send_beat(REQ_LOAD, px[23:16], px[15:8], px[7:0], 12'($urandom), i == n - 1);
    end
    for (i = 0; i < n / 2 + 1; i++) read_random($urandom_range(7) != 0);
  endtask

  task automatic test_centroid_table();
    int j;
    for (j = 0; j < 16; j++) begin
      if (j == 0) send_beat(REQ_CENT, 8'd0, 8'd0, 8'd0, 12'(j), 1'b0);
      else if (j == 1) send_beat(REQ_CENT, 8'd255, 8'd255, 8'd255, 12'(j), 1'b0);
      else send_beat(REQ_CENT, 8'($urandom), 8'($urandom), 8'($urandom), 12'(j), 1'b0);
    end
    send_beat(REQ_CENT, 8'd9, 8'd9, 8'd9, 12'd16, 1'b0);
    send_beat(REQ_CENT, 8'd9, 8'd9, 8'd9, 12'd4095, 1'b1);
    send_beat(REQ_NONE, 8'd255, 8'd255, 8'd255, 12'd4095, 1'b1);
  endtask

  task automatic test_directed();
    int i;
    set_clusters(2, 10);
    // Read before any image: every pixel is out of range.
    send_beat(REQ_READ, 8'd0, 8'd0, 8'd0, 12'd0, 1'b0);
    send_beat(REQ_CENT, 8'd0, 8'd0, 8'd0, 12'd0, 1'b0);
    send_beat(REQ_CENT, 8'd200, 8'd0, 8'd0, 12'd1, 1'b0);
    // Middle pixel sits at equal distance from both centroids; the lower index wins.
    send_beat(REQ_LOAD, 8'd100, 8'd0, 8'd0, 12'd0, 1'b0);
    send_beat(REQ_LOAD, 8'd0, 8'd0, 8'd0, 12'd0, 1'b0);
    send_beat(REQ_LOAD, 8'd255, 8'd255, 8'd255, 12'd0, 1'b0);
    send_beat(REQ_LOAD, 8'd255, 8'd1, 8'd0, 12'd0, 1'b1);
    for (i = 0; i < 4; i++) send_beat(REQ_READ, 8'd0, 8'd0, 8'd0, 12'(i), 1'b0);
    send_beat(REQ_READ, 8'd0, 8'd0, 8'd0, 12'd4, 1'b0);
    // No passes at all: every label stays at zero.
    set_clusters(3, 0);
    send_beat(REQ_LOAD, 8'd255, 8'd255, 8'd255, 12'd0, 1'b0);
    send_beat(REQ_LOAD, 8'd7, 8'd130, 8'd255, 12'd0, 1'b1);
    send_beat(REQ_READ, 8'd0, 8'd0, 8'd0, 12'd1, 1'b0);
    set_clusters(16, 255);
    random_image(12);
    set_clusters(1, 1);
    random_image(5);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int k, int iters);
    int items;
    set_clusters(k, iters);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    items = 0;
    while (items < 320) begin
      random_image(($urandom_range(15) == 0) ? $urandom_range(40, 100) : $urandom_range(2, 20));
      items += 30;
      if ($urandom_range(3) == 0) set_clusters($urandom_range(1, 16), $urandom_range(1, 12));
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    int i;
    drain();
    hold_arm = 1'b1;
    for (i = 0; i < 60; i++) read_random(1'b1);
    drain();
    for (i = 0; i < 20; i++) read_random(1'b1);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_NONE;
    in_ch.red      = '0;
    in_ch.green    = '0;
    in_ch.blue     = '0;
    in_ch.slot     = '0;
    in_ch.last_pixel = 1'b0;
    out_ch.ready   = 1'b0;
    err_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_arm       = 1'b0;
    holding        = 1'b0;
    pix_cnt        = 0;
    img_done       = 1'b0;
    k_reg          = NUM_CLUSTERS_RST;
    iter_reg       = MAX_ITER_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_centroid_table();
    test_directed();
    test_random_phase(0, 0, 4, 10);
    test_random_phase(64, 0, 8, 20);
    test_random_phase(0, 64, 16, 5);
    test_random_phase(28, 28, 3, 255);
    test_backpressure();
    drain();

    if (err_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #500ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
sv/kcq_pkg.sv
sv/kcq_in_if.sv
sv/kcq_out_if.sv
sv/kcq_div.sv
sv/kmeans_color_quantizer.sv
test/tb_kmeans_color_quantizer.sv
